### hw/rtl/udd_pkg.sv
// Shared types and constants for the unicycle-to-differential-drive command block.
// Holds the CORDIC pipeline word, the arctangent table and the fixed-point limits.
// No dependencies.
`default_nettype none

package udd_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  // Datapath widths inside the CORDIC chain.
  localparam int XY_W = 36;  // vector coordinates, input scaled by 2^16 plus growth
  localparam int Z_W  = 34;  // angle in Q3.28, wide enough for raw Q4.11 headings

  // Operation codes.
  localparam logic OP_POINT   = 1'b0;
  localparam logic OP_HEADING = 1'b1;

  // Register map: register index is paddr[2].
  localparam logic REG_MAX_OMEGA = 1'b0;
  localparam logic [15:0] MAX_OMEGA_RESET = 16'd24000;

  localparam logic signed [Z_W-1:0] ANG_PI     = 34'sd843314857;
  localparam logic signed [Z_W-1:0] ANG_TWO_PI = 34'sd1686629714;

  // 1/1.6467602581 in Q1.30
  localparam logic [29:0] MAG_GAIN = 30'd652032874;

  localparam logic signed [27:0] OUT_MAX = 28'sd8388607;
  localparam logic signed [27:0] OUT_MIN = -28'sd8388608;

  // atan(2^-i) in Q3.28
  localparam logic [27:0] ATAN_TABLE [ATAN_LEN] = '{
    28'd210828714, 28'd124459457, 28'd65760959, 28'd32252652,
    28'd16755422,  28'd8385879,   28'd4193963,  28'd2097109,
    28'd1048571,   28'd524287,    28'd262144,   28'd131072,
    28'd65536,     28'd32768,     28'd16384,    28'd8192,
    28'd4096,      28'd2048,      28'd1024,     28'd512,
    28'd256,       28'd128,       28'd64,       28'd32
  };

  typedef struct packed {
    logic                   op;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cell_data_t;

endpackage

`default_nettype wire

### hw/rtl/udd_cordic_cell.sv
// One cell of the vectoring CORDIC chain: a micro-rotation for point tracking,
// or one wrap step toward (-pi, pi] for heading tracking. Registered output.
// Depends on udd_pkg.
`default_nettype none

module udd_cordic_cell
  import udd_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire cell_data_t data_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output cell_data_t      data_o
);

  logic                   valid_q;
  cell_data_t             data_q, data_d;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  atan_s;

  assign dx     = data_i.y >>> STAGE;
  assign dy     = data_i.x >>> STAGE;
  assign atan_s = $signed({{(Z_W-28){1'b0}}, ATAN_TABLE[STAGE]});

  always_comb begin
    data_d = data_i;
    if (data_i.op == OP_POINT) begin
      if (data_i.y[XY_W-1]) begin
        data_d.x = data_i.x - dx;
        data_d.y = data_i.y + dy;
        data_d.z = data_i.z - atan_s;
      end else begin
        data_d.x = data_i.x + dx;
        data_d.y = data_i.y - dy;
        data_d.z = data_i.z + atan_s;
      end
    end else begin
      // wrap by one turn toward the principal range
      if (data_i.z > ANG_PI) begin
        data_d.z = data_i.z - ANG_TWO_PI;
      end else if (data_i.z <= -ANG_PI) begin
        data_d.z = data_i.z + ANG_TWO_PI;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### hw/rtl/udd_gain.sv
// CORDIC gain correction: magnitude = (X * MAG_GAIN + 2^45) >> 46, split into two
// partial products and a registered sum. Also clears the angle of a zero goal.
// Depends on udd_pkg.
`default_nettype none

module udd_gain
  import udd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire cell_data_t data_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output logic [16:0]     speed_o,
  output logic signed [Z_W-1:0] angle_o
);

  // stage 1: partial products
  logic                  v1_q;
  logic                  en1;
  logic [XY_W-2:0]       mag_x;
  logic [47:0]           lo_q;
  logic [46:0]           hi_q;
  logic signed [Z_W-1:0] z1_q;
  logic                  zero1_q;
  // stage 2: sum and rounding
  logic                  v2_q;
  logic                  en2;
  logic [64:0]           sum;
  logic [16:0]           speed_q;
  logic signed [Z_W-1:0] angle_q;

  // drop a negative residue to zero
  assign mag_x = data_i.x[XY_W-1] ? '0 : data_i.x[XY_W-2:0];

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      lo_q    <= mag_x[17:0] * MAG_GAIN;
      hi_q    <= mag_x[XY_W-2:18] * MAG_GAIN;
      z1_q    <= data_i.z;
      zero1_q <= data_i.zero && (data_i.op == OP_POINT);
    end
  end

  assign sum = {hi_q, 18'd0} + {17'd0, lo_q} + 65'd35184372088832;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      speed_q <= sum[62:46];
      angle_q <= zero1_q ? '0 : z1_q;
    end
  end

  assign valid_o = v2_q;
  assign speed_o = speed_q;
  assign angle_o = angle_q;

endmodule

`default_nettype wire

### hw/rtl/udd_mix.sv
// Wheel mixing: turn product max_omega * angle, then right = v + w/2 and
// left = v - w/2 with rounding and 24-bit saturation. Holds the output register.
// Depends on udd_pkg.
`default_nettype none

module udd_mix
  import udd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [15:0]           max_omega_i,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [16:0]           speed_i,
  input  wire logic signed [Z_W-1:0] angle_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic signed [23:0]         right_o,
  output logic signed [23:0]         left_o,
  output logic                       sat_o
);

  logic                  v1_q, v2_q;
  logic                  en1, en2;
  logic signed [50:0]    prod;
  logic signed [50:0]    prod_q;
  logic [16:0]           speed_q;
  logic signed [52:0]    base, p_ext, r_sum, l_sum;
  logic signed [27:0]    r_raw, l_raw;
  logic signed [23:0]    r_clip, l_clip;
  logic                  r_hit, l_hit;
  logic signed [23:0]    right_q, left_q;
  logic                  sat_q;

  assign prod = $signed({1'b0, max_omega_i}) * angle_i;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      prod_q  <= prod;
      speed_q <= speed_i;
    end
  end

  assign base  = $signed({11'd0, speed_q, 25'd0}) + 53'sd16777216;
  assign p_ext = {{2{prod_q[50]}}, prod_q};
  assign r_sum = base + p_ext;
  assign l_sum = base - p_ext;
  assign r_raw = r_sum[52:25];
  assign l_raw = l_sum[52:25];

  always_comb begin
    r_hit  = 1'b0;
    l_hit  = 1'b0;
    r_clip = r_raw[23:0];
    l_clip = l_raw[23:0];
    if (r_raw > OUT_MAX) begin
      r_hit  = 1'b1;
      r_clip = OUT_MAX[23:0];
    end else if (r_raw < OUT_MIN) begin
      r_hit  = 1'b1;
      r_clip = OUT_MIN[23:0];
    end
    if (l_raw > OUT_MAX) begin
      l_hit  = 1'b1;
      l_clip = OUT_MAX[23:0];
    end else if (l_raw < OUT_MIN) begin
      l_hit  = 1'b1;
      l_clip = OUT_MIN[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      right_q <= r_clip;
      left_q  <= l_clip;
      sat_q   <= r_hit || l_hit;
    end
  end

  assign valid_o = v2_q;
  assign right_o = right_q;
  assign left_o  = left_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire

### hw/rtl/unicycle_differential_drive_command_top.sv
// Unicycle-to-differential-drive command: top level with the CORDIC cell chain.
// Depends on udd_pkg, udd_cordic_cell, udd_gain and udd_mix.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command per transaction:
//   operation_i = 0 tracks the goal point (x_offset_i, y_offset_i), operation_i = 1
//   tracks heading_error_i. Output channel (out_valid_o / out_ready_i) returns
//   right_speed_o, left_speed_o and saturated_o, one transaction per command,
//   in order.
//   max_omega sits behind the APB port at byte address 0; write it only while no
//   command is in flight. Reads return the current value.
// Pipeline and throughput:
//   A command goes through CORDIC_STAGES chain cells, two gain stages and two
//   mixing stages, one register each; each chain cell does one micro-rotation
//   or one heading wrap step. One command is accepted per cycle while the
//   pipeline is not full of stalled results.
// Reset:
//   rst_ni clears every stage valid and loads max_omega with 1500.0 (Q12.4).
// Stalls:
//   When out_ready_i is low the result holds in the output register. Each stage
//   keeps advancing into empty slots ahead of it, so in_ready_o stays high until
//   the whole pipeline is full.
`default_nettype none

module unicycle_differential_drive_command_top
  import udd_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               operation_i,
  input  wire logic signed [15:0] x_offset_i,
  input  wire logic signed [15:0] y_offset_i,
  input  wire logic signed [15:0] heading_error_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [23:0]      right_speed_o,
  output logic signed [23:0]      left_speed_o,
  output logic                    saturated_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [15:0] max_omega_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_omega_q <= MAX_OMEGA_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_OMEGA)) begin
      max_omega_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_OMEGA) ? {16'd0, max_omega_q} : '0;

  // ---------------------------------------------------------------------------
  // Front end: scale to the chain format, fold the left half-plane
  // ---------------------------------------------------------------------------
  cell_data_t             front;
  logic signed [XY_W-1:0] xs, ys;

  assign xs = $signed({{(XY_W-32){x_offset_i[15]}}, x_offset_i, 16'd0});
  assign ys = $signed({{(XY_W-32){y_offset_i[15]}}, y_offset_i, 16'd0});

  always_comb begin
    front.op   = operation_i;
    front.zero = (x_offset_i == '0) && (y_offset_i == '0);
    front.x    = xs;
    front.y    = ys;
    front.z    = '0;
    if (operation_i == OP_HEADING) begin
      // heading enters as Q4.11 scaled to Q3.28; wrapping happens in the chain
      front.x = '0;
      front.y = '0;
      front.z = $signed({heading_error_i[15], heading_error_i, 17'd0});
    end else if (x_offset_i[15]) begin
      // goal behind: rotate by pi first
      front.x = -xs;
      front.y = -ys;
      front.z = y_offset_i[15] ? -ANG_PI : ANG_PI;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC chain
  // ---------------------------------------------------------------------------
  cell_data_t chain_data  [CORDIC_STAGES+1];
  logic       chain_valid [CORDIC_STAGES+1];
  logic       chain_ready [CORDIC_STAGES+1];

  assign chain_data[0]  = front;
  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    udd_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Gain correction and wheel mixing
  // ---------------------------------------------------------------------------
  logic                  gain_valid, mix_ready;
  logic [16:0]           speed;
  logic signed [Z_W-1:0] angle;

  udd_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[CORDIC_STAGES]),
    .ready_o (chain_ready[CORDIC_STAGES]),
    .data_i  (chain_data[CORDIC_STAGES]),
    .valid_o (gain_valid),
    .ready_i (mix_ready),
    .speed_o (speed),
    .angle_o (angle)
  );

  udd_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_omega_i (max_omega_q),
    .valid_i     (gain_valid),
    .ready_o     (mix_ready),
    .speed_i     (speed),
    .angle_i     (angle),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .right_o     (right_speed_o),
    .left_o      (left_speed_o),
    .sat_o       (saturated_o)
  );

endmodule

`default_nettype wire

### hw/rtl/udd_checker.sv
// Port-level checks for the drive command block, bound to the top level.
// Depends on udd_pkg and unicycle_differential_drive_command_top.
`default_nettype none

module udd_checker
  import udd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               operation_i,
  input wire logic signed [15:0] x_offset_i,
  input wire logic signed [15:0] y_offset_i,
  input wire logic signed [15:0] heading_error_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [23:0] right_speed_o,
  input wire logic signed [23:0] left_speed_o,
  input wire logic               saturated_o,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [2:0]         paddr,
  input wire logic [31:0]        pwdata,
  input wire logic [31:0]        prdata,
  input wire logic               pready
);

  // hold a stalled result
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(right_speed_o)
      && $stable(left_speed_o) && $stable(saturated_o))
    else $error("stalled result changed or dropped");

  // a clipped result sits on a range limit
  a_sat_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (right_speed_o == OUT_MAX[23:0]) || (right_speed_o == OUT_MIN[23:0]) ||
      (left_speed_o == OUT_MAX[23:0]) || (left_speed_o == OUT_MIN[23:0]))
    else $error("saturated flag without a clipped wheel");

  // a written max_omega reads back on the next cycle
  a_cfg_readback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == REG_MAX_OMEGA) |=>
      paddr[2] || (prdata[15:0] == $past(pwdata[15:0])))
    else $error("max_omega read back wrong value");

  // upper half of the register reads as zero
  a_cfg_upper : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && (prdata[31:16] == 16'd0))
    else $error("register read shows stray bits");

endmodule

bind unicycle_differential_drive_command_top udd_checker u_checker (.*);

`default_nettype wire

### bench/udd_wheel_cmd_checker.sv
// Checker for the unicycle-to-differential-drive command block: watches the command,
// wheel and APB transactions, predicts each wheel command and compares it.
// Depends on udd_pkg for the operation and register codes.
module udd_wheel_cmd_checker
  import udd_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               operation_i,
  input  logic signed [15:0] x_offset_i,
  input  logic signed [15:0] y_offset_i,
  input  logic signed [15:0] heading_error_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [23:0] right_speed_i,
  input  logic signed [23:0] left_speed_i,
  input  logic               saturated_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic [31:0]        prdata_i,
  input  logic               pready_i,
  output int                 mismatches_o,
  output int                 in_flight_o,
  output int                 checked_o
);

  localparam logic [15:0] GAIN_AT_RESET = 16'd24000;
  localparam longint PI_Q28     = 64'sd843314857;
  localparam longint TWO_PI_Q28 = 64'sd1686629714;
  localparam longint MAG_RECIP  = 64'sd652032874;  // 1/K of the CORDIC in Q1.30
  localparam longint WHEEL_MAX  = 64'sd8388607;
  localparam longint WHEEL_MIN  = -64'sd8388608;

  // atan(2^-i) in Q3.28, rounded to nearest
  localparam longint ATAN_Q28 [24] = '{
    210828714, 124459457, 65760959, 32252652, 16755422, 8385879, 4193963, 2097109,
    1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  typedef struct packed {
    logic signed [23:0] right;
    logic signed [23:0] left;
    logic               sat;
  } wheel_cmd_t;

  wheel_cmd_t  wheel_cmds [$];
  logic [15:0] turn_gain = GAIN_AT_RESET;
  int          mismatch_count = 0;
  int          in_flight = 0;
  int          checked = 0;

  assign mismatches_o = mismatch_count;
  assign in_flight_o  = in_flight;
  assign checked_o    = checked;

  function automatic wheel_cmd_t predict_wheel_cmd(logic op, logic signed [15:0] xo,
                                                   logic signed [15:0] yo,
                                                   logic signed [15:0] he,
                                                   logic [15:0] gain);
    longint vx, vy, dx, dy, ang, mag, turn, rsum, lsum;
    wheel_cmd_t cmd;
    ang = 0;
    mag = 0;
    cmd.sat = 1'b0;
    if (op == OP_POINT) begin
      if (xo != 0 || yo != 0) begin
        vx = longint'(xo) * 65536;
        vy = longint'(yo) * 65536;
        // fold the left half-plane over and start from +/- pi
        if (xo < 0) begin
          vx = -vx;
          vy = -vy;
          ang = (yo >= 0) ? PI_Q28 : -PI_Q28;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
          dx = vy >>> i;
          dy = vx >>> i;
          if (vy < 0) begin
            vx = vx - dx;
            vy = vy + dy;
            ang = ang - ATAN_Q28[i];
          end else begin
            vx = vx + dx;
            vy = vy - dy;
            ang = ang + ATAN_Q28[i];
          end
        end
        if (vx < 0) vx = 0;
        mag = (vx * MAG_RECIP + (64'sd1 <<< 45)) >>> 46;
      end
    end else begin
      ang = longint'(he) * 131072;
      while (ang > PI_Q28) ang = ang - TWO_PI_Q28;
      while (ang <= -PI_Q28) ang = ang + TWO_PI_Q28;
    end
    turn = longint'({48'd0, gain}) * ang;
    rsum = ((mag <<< 25) + turn + (64'sd1 <<< 24)) >>> 25;
    lsum = ((mag <<< 25) - turn + (64'sd1 <<< 24)) >>> 25;
    if (rsum > WHEEL_MAX) begin rsum = WHEEL_MAX; cmd.sat = 1'b1; end
    if (rsum < WHEEL_MIN) begin rsum = WHEEL_MIN; cmd.sat = 1'b1; end
    if (lsum > WHEEL_MAX) begin lsum = WHEEL_MAX; cmd.sat = 1'b1; end
    if (lsum < WHEEL_MIN) begin lsum = WHEEL_MIN; cmd.sat = 1'b1; end
    cmd.right = rsum[23:0];
    cmd.left  = lsum[23:0];
    return cmd;
  endfunction

  task automatic check_field(string field, logic signed [23:0] want, logic signed [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    wheel_cmd_t want;
    if (!rst_ni) begin
      turn_gain = GAIN_AT_RESET;
      wheel_cmds.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (wheel_cmds.size() == 0) begin
          $error("wheel result with no command in flight: right %0d, left %0d",
                 right_speed_i, left_speed_i);
          mismatch_count++;
        end else begin
          want = wheel_cmds.pop_front();
          check_field("right_speed", want.right, right_speed_i);
          check_field("left_speed", want.left, left_speed_i);
          check_field("saturated", {23'd0, want.sat}, {23'd0, saturated_i});
          checked++;
        end
      end
      // predict with the gain in force before any write at this edge
      if (in_valid_i && in_ready_i)
        wheel_cmds.push_back(predict_wheel_cmd(operation_i, x_offset_i, y_offset_i,
                                               heading_error_i, turn_gain));
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_MAX_OMEGA) begin
        if (pwrite_i) begin
          turn_gain = pwdata_i[15:0];
        end else if (prdata_i !== {16'd0, turn_gain}) begin
          $error("max_omega: expected %0d, got %0d", turn_gain, prdata_i);
          mismatch_count++;
        end
      end
    end
    in_flight = wheel_cmds.size();
  end

endmodule

### bench/unicycle_differential_drive_command_top_tb.sv
// Testbench top for the unicycle-to-differential-drive command block: drives bursty
// commands, a stalling wheel receiver and APB gain writes, and gives the verdict.
// Depends on udd_pkg, unicycle_differential_drive_command_top and udd_wheel_cmd_checker.
module unicycle_differential_drive_command_top_tb;
  import udd_pkg::*;

  localparam int CORDIC_STAGES = CORDIC_STAGES_DEF;
  // settle time after the last wheel result: pipeline depth plus margin
  localparam int DRAIN_CYCLES = CORDIC_STAGES + 8;
  // cycles with no transaction at all before the run is declared hung
  localparam int IDLE_LIMIT = 4000;
  localparam int GAIN_PHASES = 7;
  localparam logic [2:0] GAIN_ADDR     = {REG_MAX_OMEGA, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR = {~REG_MAX_OMEGA, 2'b00};
  // odd multiples of pi in Q4.11: the heading wrap boundaries
  localparam int PI_STEPS [3] = '{6434, 19302, 32170};

  typedef enum logic [1:0] {
    SINK_FREE,  // always ready
    SINK_COIN,  // ready half the time
    SINK_SLOW,  // ready a quarter of the time on average
    SINK_BEAT   // fixed beat: stalls a quarter of the time, in one run per beat period
  } sink_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               operation_i = OP_POINT;
  logic signed [15:0] x_offset_i = '0;
  logic signed [15:0] y_offset_i = '0;
  logic signed [15:0] heading_error_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [23:0] right_speed_o;
  logic signed [23:0] left_speed_o;
  logic               saturated_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches, in_flight, checked;
  int burst_left = 0;
  int point_cmds = 0;
  int heading_cmds = 0;
  int idle_cycles = 0;
  sink_mode_e sink_mode = SINK_FREE;
  int sink_left = 0;
  logic [2:0] sink_beat = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  unicycle_differential_drive_command_top #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .operation_i, .x_offset_i, .y_offset_i, .heading_error_i,
    .out_valid_o, .out_ready_i, .right_speed_o, .left_speed_o, .saturated_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  udd_wheel_cmd_checker #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .x_offset_i, .y_offset_i,
    .heading_error_i,
    .out_valid_i(out_valid_o), .out_ready_i, .right_speed_i(right_speed_o),
    .left_speed_i(left_speed_o), .saturated_i(saturated_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .mismatches_o(mismatches), .in_flight_o(in_flight), .checked_o(checked)
  );

  // Wheel receiver: switch stall mode when a random countdown runs out so back-pressure
  // lands on every pipeline phase, with free-running stretches among the modes.
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 3));
      sink_left <= $urandom_range(32, 300);
    end else begin
      sink_left <= sink_left - 1;
    end
    sink_beat <= sink_beat + 3'd1;
    case (sink_mode)
      SINK_FREE: out_ready_i <= 1'b1;
      SINK_COIN: out_ready_i <= 1'($urandom_range(0, 1));
      SINK_SLOW: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (sink_beat[2:1] != 2'b10);
    endcase
  end

  // Watchdog: any transaction on either channel or the APB port restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("unicycle_differential_drive_command_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One APB transfer: setup, then access until pready, then back to idle.
  // Call at a rising edge.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one command and hold it until the transaction completes. Between bursts,
  // drop valid for a random gap; within a burst keep valid high for the next one.
  task automatic send_cmd(input logic op, input logic signed [15:0] xo,
                          input logic signed [15:0] yo, input logic signed [15:0] he);
    int gap;
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    x_offset_i      <= xo;
    y_offset_i      <= yo;
    heading_error_i <= he;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_POINT) point_cmds++;
    else heading_cmds++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid and wait until every predicted wheel command has come back.
  // Sample the in-flight count away from the rising edge, then realign.
  task automatic drain;
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (in_flight != 0);
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return -16'sd32768;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // Random commands: full-range fields as the base (unused fields included),
  // overlaid with small vectors and headings, axis-aligned goals, extremes and wrap boundaries.
  task automatic send_random_cmds(input int count);
    logic               op;
    logic signed [15:0] xo, yo, he;
    repeat (count) begin
      op = 1'($urandom_range(0, 1));
      xo = 16'($urandom);
      yo = 16'($urandom);
      he = 16'($urandom);
      case ($urandom_range(0, 6))
        0: begin
          xo = 16'(int'($urandom_range(0, 1023)) - 512);
          yo = 16'(int'($urandom_range(0, 1023)) - 512);
        end
        1: if ($urandom_range(0, 1)) xo = '0; else yo = '0;
        2: begin
          xo = pick_extreme();
          yo = pick_extreme();
          he = pick_extreme();
        end
        3: he = 16'(($urandom_range(0, 1) ? 1 : -1) *
                    (PI_STEPS[$urandom_range(0, 2)] + int'($urandom_range(0, 4)) - 2));
        4: he = 16'(int'($urandom_range(0, 255)) - 128);
        default: ;
      endcase
      send_cmd(op, xo, yo, he);
    end
  endtask

  initial begin
    logic [15:0] gains [GAIN_PHASES];
    gains = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'($urandom), 16'($urandom),
              MAX_OMEGA_RESET};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gain: read it back, then the directed corners.
    apb_access(1'b0, GAIN_ADDR, '0);
    // zero goal, goal straight ahead and straight behind, behind from each side
    send_cmd(OP_POINT, 16'sd0, 16'sd0, 16'($urandom));
    send_cmd(OP_POINT, 16'sd256, 16'sd0, 16'($urandom));
    send_cmd(OP_POINT, -16'sd256, 16'sd0, 16'($urandom));
    send_cmd(OP_POINT, -16'sd1, 16'sd0, 16'($urandom));
    send_cmd(OP_POINT, -16'sd256, -16'sd1, 16'($urandom));
    send_cmd(OP_POINT, -16'sd256, 16'sd1, 16'($urandom));
    // field extremes in every quadrant and on the lateral axis
    send_cmd(OP_POINT, 16'sd32767, 16'sd32767, 16'($urandom));
    send_cmd(OP_POINT, -16'sd32768, -16'sd32768, 16'($urandom));
    send_cmd(OP_POINT, 16'sd32767, -16'sd32768, 16'($urandom));
    send_cmd(OP_POINT, -16'sd32768, 16'sd32767, 16'($urandom));
    send_cmd(OP_POINT, 16'sd0, 16'sd32767, 16'($urandom));
    send_cmd(OP_POINT, 16'sd0, -16'sd32768, 16'($urandom));
    // headings: zero, one LSB, both sides of +/- pi, and the field extremes
    send_cmd(OP_HEADING, 16'($urandom), 16'($urandom), 16'sd0);
    send_cmd(OP_HEADING, 16'($urandom), 16'($urandom), 16'sd1);
    send_cmd(OP_HEADING, 16'($urandom), 16'($urandom), 16'sd6433);
    send_cmd(OP_HEADING, 16'($urandom), 16'($urandom), 16'sd6434);
    send_cmd(OP_HEADING, 16'($urandom), 16'($urandom), -16'sd6433);
    send_cmd(OP_HEADING, 16'($urandom), 16'($urandom), -16'sd6434);
    send_cmd(OP_HEADING, 16'($urandom), 16'($urandom), 16'sd32767);
    send_cmd(OP_HEADING, 16'($urandom), 16'($urandom), -16'sd32768);
    send_random_cmds(90);
    drain();

    // Walk the gain through its extremes and a few random values. Each phase
    // also pokes the unmapped address, which must leave the gain untouched.
    for (int ph = 0; ph < GAIN_PHASES; ph++) begin
      apb_access(1'b1, GAIN_ADDR, {16'($urandom), gains[ph]});
      apb_access(1'b1, UNMAPPED_ADDR, $urandom);
      apb_access(1'b0, GAIN_ADDR, '0);
      send_random_cmds(95);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d point and %0d heading commands over %0d gain settings,",
             point_cmds, heading_cmds, GAIN_PHASES + 1);
    $display("%0d wheel results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("unicycle_differential_drive_command_top regression: pass");
    end else begin
      $display("unicycle_differential_drive_command_top regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/udd_pkg.sv
hw/rtl/udd_cordic_cell.sv
hw/rtl/udd_gain.sv
hw/rtl/udd_mix.sv
hw/rtl/unicycle_differential_drive_command_top.sv
hw/rtl/udd_checker.sv
bench/udd_wheel_cmd_checker.sv
bench/unicycle_differential_drive_command_top_tb.sv
